/* rtl/core/f2f_biphase_encoder_unit_assert.svh */
// Assertion macros for the F2F biphase encoder unit
`ifndef F2F_BIPHASE_ENCODER_UNIT_ASSERT_SVH
`define F2F_BIPHASE_ENCODER_UNIT_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define F2F_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the cycle after its trigger
`define F2F_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/f2f_pkg.sv */
// Shared types and constants of the F2F biphase encoder
package f2f_pkg;

	localparam logic [6:0] SYNC_MAX   = 7'd100;
	localparam logic [6:0] SYNC_RESET = 7'd20;
	localparam logic [3:0] BITS_MAX   = 4'd8;

	typedef enum logic [0:0] {
		CFG_SYNC_CELLS    = 1'b0,
		CFG_BITS_PER_CHAR = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_char;
		logic       last_char;
		logic [6:0] lead_cells;
		logic [7:0] data_end;
		logic [7:0] total_cells;
	} item_t;

endpackage

/* rtl/core/f2f_char_if.sv */
// Character channel: valid/ready handshake with one character per item
interface f2f_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_char;
	logic       last_char;

	modport source (output valid, data_char, last_char, input ready);
	modport sink (input valid, data_char, last_char, output ready);
endinterface

/* rtl/core/f2f_byte_if.sv */
// Byte channel: valid/ready handshake with one packed half-bit byte per item
interface f2f_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  packed_halves;
	logic [3:0]  valid_halves;
	logic        last_byte;
	logic [15:0] total_halves;

	modport source (output valid, packed_halves, valid_halves, last_byte, total_halves,
		input ready);
	modport sink (input valid, packed_halves, valid_halves, last_byte, total_halves,
		output ready);
endinterface

/* rtl/core/f2f_front.sv */
// Front end: configuration registers, message tracking and cell plan of each character
module f2f_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [6:0]          cfg_wdata,
	f2f_char_if.sink            chars,
	input  logic                q_full,
	output logic                push,
	output f2f_pkg::item_t      push_item
);

	logic [6:0] sync_q;
	logic [3:0] bits_q;
	logic       open_q;
	logic [6:0] sync_eff;
	logic [3:0] bits_eff;
	logic [6:0] lead;
	logic [6:0] trail;
	logic [7:0] data_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= f2f_pkg::SYNC_RESET;
			bits_q <= f2f_pkg::BITS_MAX;
		end else if (cfg_we) begin
			unique case (f2f_pkg::cfg_idx_t'(cfg_idx))
				f2f_pkg::CFG_SYNC_CELLS:    sync_q <= cfg_wdata;
				f2f_pkg::CFG_BITS_PER_CHAR: bits_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign chars.ready = !q_full;
	assign push        = chars.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (push) begin
			open_q <= !chars.last_char;
		end
	end

	assign sync_eff = (sync_q > f2f_pkg::SYNC_MAX) ? f2f_pkg::SYNC_MAX : sync_q;
	assign bits_eff = (bits_q > f2f_pkg::BITS_MAX) ? f2f_pkg::BITS_MAX : bits_q;
	assign lead     = open_q ? 7'd0 : sync_eff;
	assign trail    = chars.last_char ? sync_eff : 7'd0;
	assign data_end = {1'b0, lead} + {4'd0, bits_eff};

	always_comb begin
		push_item.data_char   = chars.data_char;
		push_item.last_char   = chars.last_char;
		push_item.lead_cells  = lead;
		push_item.data_end    = data_end;
		push_item.total_cells = data_end + {1'b0, trail};
	end

endmodule

/* rtl/core/f2f_queue.sv */
// Small FIFO of planned characters between front and back
module f2f_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  f2f_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output f2f_pkg::item_t head,
	output logic           head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	f2f_pkg::item_t store_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = store_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/core/f2f_back.sv */
// Back end: turns up to four cells per cycle into half-bits and packs bytes, unless the byte output stalls it
module f2f_back (
	input  logic           clk,
	input  logic           arst_n,
	input  f2f_pkg::item_t head,
	input  logic           head_valid,
	output logic           pop,
	f2f_byte_if.source     bytes
);

	logic        level_q;
	logic [7:0]  pend_q;
	logic [1:0]  pos_q;
	logic [15:0] hc_q;
	logic [7:0]  cidx_q;

	logic        out_valid_q;
	logic [7:0]  out_packed_q;
	logic [3:0]  out_halves_q;
	logic        out_last_q;
	logic [15:0] out_total_q;

	logic [7:0]  rem;
	logic [2:0]  room;
	logic [2:0]  take;
	logic        done;
	logic [2:0]  new_pos;
	logic        full;
	logic        lev;
	logic [7:0]  byte_d;
	logic [1:0]  off;
	logic [7:0]  idx;
	logic [7:0]  didx;
	logic        cell_bit;
	logic [16:0] hc_sum;
	logic [15:0] hc_next;
	logic        fin;
	logic        need_emit;
	logic        out_free;
	logic        advance;

	assign rem     = head.total_cells - cidx_q;
	assign room    = 3'd4 - {1'b0, pos_q};
	assign take    = (rem < {5'd0, room}) ? rem[2:0] : room;
	assign done    = (rem == {5'd0, take});
	assign new_pos = {1'b0, pos_q} + take;
	assign full    = new_pos[2];

	always_comb begin
		lev      = level_q;
		byte_d   = pend_q;
		off      = '0;
		idx      = '0;
		didx     = '0;
		cell_bit = 1'b0;
		for (int s = 0; s < 4; s++) begin
			if (3'(s) >= {1'b0, pos_q} && 3'(s) < new_pos) begin
				off      = 2'(s) - pos_q;
				idx      = cidx_q + {6'd0, off};
				didx     = idx - {1'b0, head.lead_cells};
				cell_bit = (idx >= {1'b0, head.lead_cells}) && (idx < head.data_end)
					&& head.data_char[didx[2:0]];
				byte_d[2*s]   = !lev;
				byte_d[2*s+1] = cell_bit ? lev : !lev;
				lev           = byte_d[2*s+1];
			end
		end
	end

	assign hc_sum    = {1'b0, hc_q} + {13'd0, take, 1'b0};
	assign hc_next   = hc_sum[16] ? 16'hFFFF : hc_sum[15:0];
	assign fin       = done && head.last_char;
	assign need_emit = full || fin;
	assign out_free  = !out_valid_q || bytes.ready;
	assign advance   = head_valid && (!need_emit || out_free);
	assign pop       = advance && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			pend_q  <= '0;
			pos_q   <= '0;
			hc_q    <= '0;
			cidx_q  <= '0;
		end else if (advance) begin
			if (fin) begin
				level_q <= 1'b0;
				pend_q  <= '0;
				pos_q   <= '0;
				hc_q    <= '0;
			end else begin
				level_q <= lev;
				hc_q    <= hc_next;
				pend_q  <= full ? 8'd0 : byte_d;
				pos_q   <= full ? 2'd0 : new_pos[1:0];
			end
			cidx_q <= done ? 8'd0 : cidx_q + {5'd0, take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && need_emit) begin
			out_valid_q <= 1'b1;
		end else if (bytes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && need_emit) begin
			out_packed_q <= byte_d;
			out_halves_q <= {new_pos, 1'b0};
			out_last_q   <= fin;
			out_total_q  <= fin ? hc_next : 16'd0;
		end
	end

	assign bytes.valid         = out_valid_q;
	assign bytes.packed_halves = out_packed_q;
	assign bytes.valid_halves  = out_halves_q;
	assign bytes.last_byte     = out_last_q;
	assign bytes.total_halves  = out_total_q;

endmodule

/* rtl/core/f2f_biphase_encoder_unit.sv */
// Top level of the F2F biphase encoder: front, character queue and byte packer
// Characters enter on chars and leave as bytes of eight half-bit line levels, earliest in
// bit 0. The packer handles up to four cells (one byte) per cycle while the byte output
// does not stall it, and never runs a cycle past a byte boundary. A character holds its
// data cells, plus sync_cells (capped at 100) on the first character of a message and
// again on the last. The zero-padded partial byte of the last character is registered in
// that character's final cycle. With eight bits per character the message body starts on
// a byte boundary when sync_cells is a multiple of four, and each character then fills
// exactly two bytes; otherwise each character spans three bytes. A queue of QUEUE_DEPTH
// planned characters lets the input keep flowing while the byte output stalls.
module f2f_biphase_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [6:0]  cfg_wdata,
	f2f_char_if.sink    chars,
	f2f_byte_if.source  bytes
);

	`include "f2f_biphase_encoder_unit_assert.svh"

	f2f_pkg::item_t push_item;
	f2f_pkg::item_t head;
	logic           push;
	logic           q_full;
	logic           head_valid;
	logic           pop;

	f2f_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.chars     (chars),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	f2f_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	f2f_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.bytes      (bytes)
	);

	`F2F_ASSERT_HOLDS(a_inner_byte_full, bytes.valid && !bytes.last_byte, bytes.valid_halves == 4'd8 && bytes.total_halves == 16'd0, "non-final byte not full or carries a total")
	`F2F_ASSERT_HOLDS(a_empty_marker, bytes.valid && bytes.valid_halves == 4'd0, bytes.last_byte && bytes.packed_halves == 8'd0, "empty byte is not a clean end marker")
	`F2F_ASSERT_HOLDS(a_whole_cells, bytes.valid, !bytes.valid_halves[0] && bytes.valid_halves <= 4'd8, "byte holds a split cell")
	`F2F_ASSERT_HOLDS(a_pop_needs_head, pop, head_valid, "queue popped while empty")

endmodule
